FILE: sv/mbrtu_pkg.sv
// ----------------------------------------------------------------------------
// mbrtu_pkg
// Shared constants, types and the CRC-16 step for the Modbus RTU register
// server: function codes, controller states, command and status bundles.
// ----------------------------------------------------------------------------
package mbrtu_pkg;

	// Sizes
	localparam int REG_COUNT = 100;
	localparam int FRAME_BUF = 256;
	localparam int MAX_READ  = 29;
	localparam int REG_AW    = $clog2(REG_COUNT);
	localparam int FB_AW     = $clog2(FRAME_BUF);
	localparam int CNT_W     = 8;
	localparam int WIDX_W    = 7;

	// Frame layout
	localparam int HDR_LEN        = 7;
	localparam int BASIC_LEN      = 8;
	localparam int MULTI_OVERHEAD = 9;
	localparam int COIL_OVERHEAD  = 9;
	localparam int WM_DATA_HI     = 7;
	localparam int WM_DATA_LO     = 8;
	localparam int HEAD_LEN_READ  = 3;
	localparam int HEAD_LEN_WRITE = 6;
	localparam int MIN_CHECK_CNT  = 4;

	localparam logic [15:0] CRC_INIT       = 16'hFFFF;
	localparam logic [15:0] CRC_POLY       = 16'hA001;
	localparam logic [7:0]  SLAVE_ADDR_RST = 8'd1;
	localparam logic [15:0] SAVE_LO        = 16'd20;
	localparam logic [15:0] SAVE_HI        = 16'd39;

	// Function codes
	localparam logic [7:0] FC_READ_COILS   = 8'd1;
	localparam logic [7:0] FC_READ_HOLD    = 8'd3;
	localparam logic [7:0] FC_WRITE_COIL   = 8'd5;
	localparam logic [7:0] FC_WRITE_SINGLE = 8'd6;
	localparam logic [7:0] FC_WRITE_COILS  = 8'd15;
	localparam logic [7:0] FC_WRITE_MULTI  = 8'd16;

	typedef enum logic [2:0] {
		K_NOP,
		K_READ,
		K_WSINGLE,
		K_WCOILS,
		K_WMULTI,
		K_OTHER
	} kind_t;

	typedef enum logic [1:0] {
		RS_SEQ,
		RS_WM_HI,
		RS_WM_LO
	} rd_src_t;

	typedef enum logic [2:0] {
		SEL_HEAD,
		SEL_WHI,
		SEL_WLO,
		SEL_CRCLO,
		SEL_CRCHI
	} tx_sel_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_CHK,
		ST_HD_RUN,
		ST_HD_WAIT,
		ST_DECIDE,
		ST_CK_RUN,
		ST_CK_WAIT,
		ST_CK_EVAL,
		ST_WM_CHK,
		ST_WM_RHI,
		ST_WM_RLO,
		ST_WM_WR,
		ST_EM_HEAD,
		ST_EM_RREQ,
		ST_EM_RCAP,
		ST_EM_WHI,
		ST_EM_WLO,
		ST_EM_CRCLO,
		ST_EM_CRCHI,
		ST_CONSUME
	} state_t;

	typedef struct packed {
		logic    rx_take;
		logic    cnt_clr;
		logic    consume;
		logic    rd_clr;
		logic    rd_issue;
		rd_src_t rd_src;
		logic    hdr_cap;
		logic    ck_start;
		logic    ck_en;
		logic    wm_hi_cap;
		logic    reg_wr;
		logic    reg_wr_single;
		logic    reg_rd;
		logic    word_cap;
		logic    em_start;
		logic    emit;
		tx_sel_t tx_sel;
		logic    head_adv;
		logic    widx_inc;
	} cmd_t;

	typedef struct packed {
		logic  count_gt4;
		kind_t kind;
		logic  frame_ready;
		logic  accept;
		logic  hdr_last;
		logic  ck_last;
		logic  crc_ok;
		logic  read_too_long;
		logic  read_empty;
		logic  wm_done;
		logic  head_last;
		logic  words_last;
		logic  out_free;
	} status_t;

	// One byte through CRC-16/MODBUS, reflected
	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

FILE: sv/mbrtu_ram.sv
// ----------------------------------------------------------------------------
// mbrtu_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mbrtu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: sv/mbrtu_ctrl.sv
// ----------------------------------------------------------------------------
// mbrtu_ctrl
// Controller: sequences header fetch, CRC check, register writes and
// response emission for each received byte.
// ----------------------------------------------------------------------------
module mbrtu_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  mbrtu_pkg::status_t st,
	output mbrtu_pkg::cmd_t    cmd
);

	import mbrtu_pkg::*;

	state_t state_q, state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_CHK;
			end
			ST_CHK: begin
				state_d = st.count_gt4 ? ST_HD_RUN : ST_IDLE;
			end
			ST_HD_RUN: begin
				if (st.hdr_last) state_d = ST_HD_WAIT;
			end
			ST_HD_WAIT: state_d = ST_DECIDE;
			ST_DECIDE: begin
				if (st.kind == K_OTHER || !st.frame_ready) begin
					state_d = ST_IDLE;
				end else if (st.accept && st.kind inside {K_READ, K_WSINGLE, K_WMULTI}) begin
					state_d = ST_CK_RUN;
				end else begin
					state_d = ST_CONSUME;
				end
			end
			ST_CK_RUN: begin
				if (st.ck_last) state_d = ST_CK_WAIT;
			end
			ST_CK_WAIT: state_d = ST_CK_EVAL;
			ST_CK_EVAL: begin
				if (!st.crc_ok) begin
					state_d = ST_CONSUME;
				end else if (st.kind == K_READ) begin
					state_d = st.read_too_long ? ST_CONSUME : ST_EM_HEAD;
				end else if (st.kind == K_WSINGLE) begin
					state_d = ST_EM_HEAD;
				end else begin
					state_d = ST_WM_CHK;
				end
			end
			ST_WM_CHK: state_d = st.wm_done ? ST_EM_HEAD : ST_WM_RHI;
			ST_WM_RHI: state_d = ST_WM_RLO;
			ST_WM_RLO: state_d = ST_WM_WR;
			ST_WM_WR:  state_d = ST_WM_CHK;
			ST_EM_HEAD: begin
				if (st.out_free && st.head_last) begin
					if (st.kind == K_READ && !st.read_empty) begin
						state_d = ST_EM_RREQ;
					end else begin
						state_d = ST_EM_CRCLO;
					end
				end
			end
			ST_EM_RREQ: state_d = ST_EM_RCAP;
			ST_EM_RCAP: state_d = ST_EM_WHI;
			ST_EM_WHI: begin
				if (st.out_free) state_d = ST_EM_WLO;
			end
			ST_EM_WLO: begin
				if (st.out_free) state_d = st.words_last ? ST_EM_CRCLO : ST_EM_RREQ;
			end
			ST_EM_CRCLO: begin
				if (st.out_free) state_d = ST_EM_CRCHI;
			end
			ST_EM_CRCHI: begin
				if (st.out_free) state_d = ST_CONSUME;
			end
			ST_CONSUME: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		cmd = '0;
		cmd.rd_src = RS_SEQ;
		cmd.tx_sel = SEL_HEAD;
		in_stall = (state_q != ST_IDLE);
		case (state_q)
			ST_IDLE: cmd.rx_take = in_valid;
			ST_CHK:  cmd.rd_clr = 1'b1;
			ST_HD_RUN: begin
				cmd.rd_issue = 1'b1;
				cmd.hdr_cap  = 1'b1;
			end
			ST_HD_WAIT: cmd.hdr_cap = 1'b1;
			ST_DECIDE: begin
				if (st.kind == K_OTHER) begin
					cmd.cnt_clr = 1'b1;
				end else if (st.frame_ready && st.accept
						&& st.kind inside {K_READ, K_WSINGLE, K_WMULTI}) begin
					cmd.ck_start = 1'b1;
				end
			end
			ST_CK_RUN: begin
				cmd.rd_issue = 1'b1;
				cmd.ck_en    = 1'b1;
			end
			ST_CK_WAIT: cmd.ck_en = 1'b1;
			ST_CK_EVAL: begin
				if (st.crc_ok) begin
					if (st.kind == K_READ && !st.read_too_long) begin
						cmd.em_start = 1'b1;
					end else if (st.kind == K_WSINGLE) begin
						cmd.reg_wr        = 1'b1;
						cmd.reg_wr_single = 1'b1;
						cmd.em_start      = 1'b1;
					end
				end
			end
			ST_WM_CHK: cmd.em_start = st.wm_done;
			ST_WM_RHI: cmd.rd_src = RS_WM_HI;
			ST_WM_RLO: begin
				cmd.rd_src    = RS_WM_LO;
				cmd.wm_hi_cap = 1'b1;
			end
			ST_WM_WR: begin
				cmd.reg_wr   = 1'b1;
				cmd.widx_inc = 1'b1;
			end
			ST_EM_HEAD: begin
				cmd.emit     = st.out_free;
				cmd.head_adv = st.out_free;
				cmd.tx_sel   = SEL_HEAD;
			end
			ST_EM_RREQ: cmd.reg_rd = 1'b1;
			ST_EM_RCAP: cmd.word_cap = 1'b1;
			ST_EM_WHI: begin
				cmd.emit   = st.out_free;
				cmd.tx_sel = SEL_WHI;
			end
			ST_EM_WLO: begin
				cmd.emit     = st.out_free;
				cmd.widx_inc = st.out_free;
				cmd.tx_sel   = SEL_WLO;
			end
			ST_EM_CRCLO: begin
				cmd.emit   = st.out_free;
				cmd.tx_sel = SEL_CRCLO;
			end
			ST_EM_CRCHI: begin
				cmd.emit   = st.out_free;
				cmd.tx_sel = SEL_CRCHI;
			end
			ST_CONSUME: cmd.consume = 1'b1;
			default: cmd = '0;
		endcase
	end

endmodule

FILE: sv/mbrtu_dp.sv
// ----------------------------------------------------------------------------
// mbrtu_dp
// Datapath: frame buffer, header registers, CRC check, register store with
// valid bits, response byte generator and output register.
// ----------------------------------------------------------------------------
module mbrtu_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [7:0]         cfg_wr_data,
	input  logic [7:0]         rx_byte,
	input  logic               frame_start,
	input  logic               parity_error,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [7:0]         tx_byte,
	output logic               last_byte,
	output logic               save_request,
	input  mbrtu_pkg::cmd_t    cmd,
	output mbrtu_pkg::status_t st
);

	import mbrtu_pkg::*;

	logic [7:0]         slave_addr_q;
	logic [CNT_W-1:0]   count_q;
	logic               err_q;
	logic [CNT_W-1:0]   rd_idx_q;
	logic               rd_vld_s1;
	logic [CNT_W-1:0]   rd_tag_s1;
	logic [7:0]         hdr_q [HDR_LEN];
	logic [15:0]        ck_crc_q;
	logic               lo_ok_q, hi_ok_q;
	logic [WIDX_W-1:0]  widx_q;
	logic [7:0]         wm_hi_q;
	logic [2:0]         head_k_q;
	logic [15:0]        word_q;
	logic [15:0]        tx_crc_q;
	logic               save_q;
	logic [REG_COUNT-1:0] reg_vld_q;
	logic               reg_vld_s1;
	logic               out_valid_q;
	logic [7:0]         tx_byte_q;
	logic               last_q;
	logic               save_out_q;

	logic [7:0]         st_rdata;
	logic [FB_AW-1:0]   st_waddr, st_raddr;
	logic [CNT_W-1:0]   cnt_base;
	logic [CNT_W:0]     cnt_next;
	logic [7:0]         wm_addr_hi, wm_addr_lo;
	logic [15:0]        hdr_addr, hdr_cnt;
	logic [17:0]        len16;
	logic [8:0]         len15;
	logic [7:0]         ck_len;
	kind_t              kind;
	logic [15:0]        reg_addr;
	logic [REG_AW-1:0]  reg_idx;
	logic               reg_in_range;
	logic               reg_save;
	logic [15:0]        reg_wdata;
	logic [15:0]        reg_rdata;
	logic [7:0]         head_byte;
	logic [7:0]         tx_next;
	logic               out_free;

	// Frame buffer
	assign st_waddr = FB_AW'(frame_start ? '0 : count_q);
	assign wm_addr_hi = 8'({widx_q, 1'b0}) + 8'(WM_DATA_HI);
	assign wm_addr_lo = 8'({widx_q, 1'b0}) + 8'(WM_DATA_LO);

	always_comb begin
		case (cmd.rd_src)
			RS_WM_HI: st_raddr = FB_AW'(wm_addr_hi);
			RS_WM_LO: st_raddr = FB_AW'(wm_addr_lo);
			default:  st_raddr = FB_AW'(rd_idx_q);
		endcase
	end

	mbrtu_ram #(.WIDTH(8), .DEPTH(FRAME_BUF)) u_frame_ram (
		.clk   (clk),
		.we    (cmd.rx_take),
		.waddr (st_waddr),
		.wdata (rx_byte),
		.raddr (st_raddr),
		.rdata (st_rdata)
	);

	// Byte count, wrapping at the buffer size
	assign cnt_base = frame_start ? '0 : count_q;
	assign cnt_next = {1'b0, cnt_base} + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			err_q        <= 1'b0;
			slave_addr_q <= SLAVE_ADDR_RST;
		end else begin
			if (cfg_wr_en) slave_addr_q <= cfg_wr_data;
			if (cmd.rx_take) begin
				count_q <= (cnt_next == (CNT_W+1)'(FRAME_BUF)) ? '0 : cnt_next[CNT_W-1:0];
				err_q   <= (frame_start ? 1'b0 : err_q) | parity_error;
			end else if (cmd.consume) begin
				count_q <= '0;
				err_q   <= 1'b0;
			end else if (cmd.cnt_clr) begin
				count_q <= '0;
			end
		end
	end

	// Sequential buffer reads with tag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q  <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (cmd.rd_clr || cmd.ck_start) rd_idx_q <= '0;
			else if (cmd.rd_issue) rd_idx_q <= rd_idx_q + 1'b1;
			rd_vld_s1 <= cmd.rd_issue;
		end
	end

	always_ff @(posedge clk) begin
		rd_tag_s1 <= rd_idx_q;
		if (cmd.hdr_cap && rd_vld_s1) hdr_q[rd_tag_s1[2:0]] <= st_rdata;
		if (cmd.wm_hi_cap) wm_hi_q <= st_rdata;
	end

	// Header decode
	assign hdr_addr = {hdr_q[2], hdr_q[3]};
	assign hdr_cnt  = {hdr_q[4], hdr_q[5]};
	assign len16    = {1'b0, hdr_cnt, 1'b0} + 18'(MULTI_OVERHEAD);
	assign len15    = {1'b0, hdr_q[6]} + 9'(COIL_OVERHEAD);

	always_comb begin
		if (hdr_q[1] inside {FC_READ_COILS, FC_WRITE_COIL}) kind = K_NOP;
		else if (hdr_q[1] == FC_READ_HOLD) kind = K_READ;
		else if (hdr_q[1] == FC_WRITE_SINGLE) kind = K_WSINGLE;
		else if (hdr_q[1] == FC_WRITE_COILS) kind = K_WCOILS;
		else if (hdr_q[1] == FC_WRITE_MULTI) kind = K_WMULTI;
		else kind = K_OTHER;
	end

	assign ck_len = (kind == K_WMULTI) ? len16[7:0] : 8'(BASIC_LEN);

	// CRC check over the buffered frame
	always_ff @(posedge clk) begin
		if (cmd.ck_start) begin
			ck_crc_q <= CRC_INIT;
			lo_ok_q  <= 1'b0;
			hi_ok_q  <= 1'b0;
		end else if (cmd.ck_en && rd_vld_s1) begin
			if (rd_tag_s1 < ck_len - 8'd2) ck_crc_q <= crc_byte(ck_crc_q, st_rdata);
			else if (rd_tag_s1 == ck_len - 8'd2) lo_ok_q <= (st_rdata == ck_crc_q[7:0]);
			else if (rd_tag_s1 == ck_len - 8'd1) hi_ok_q <= (st_rdata == ck_crc_q[15:8]);
		end
	end

	// Register store
	assign reg_addr     = hdr_addr + 16'(widx_q);
	assign reg_idx      = reg_addr[REG_AW-1:0];
	assign reg_in_range = reg_addr < 16'(REG_COUNT);
	assign reg_save     = (reg_addr < SAVE_LO) || (reg_addr > SAVE_HI);
	assign reg_wdata    = cmd.reg_wr_single ? hdr_cnt : {wm_hi_q, st_rdata};

	mbrtu_ram #(.WIDTH(16), .DEPTH(REG_COUNT)) u_reg_ram (
		.clk   (clk),
		.we    (cmd.reg_wr && reg_in_range),
		.waddr (reg_idx),
		.wdata (reg_wdata),
		.raddr (reg_idx),
		.rdata (reg_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reg_vld_q <= '0;
		end else if (cmd.reg_wr && reg_in_range) begin
			reg_vld_q[reg_idx] <= 1'b1;
		end
	end

	// Write loop index, save flag, read word
	always_ff @(posedge clk) begin
		if (cmd.ck_start || cmd.em_start) widx_q <= '0;
		else if (cmd.widx_inc) widx_q <= widx_q + 1'b1;

		if (cmd.ck_start) save_q <= 1'b0;
		else if (cmd.reg_wr && reg_in_range && reg_save) save_q <= 1'b1;

		if (cmd.reg_rd) reg_vld_s1 <= reg_in_range ? reg_vld_q[reg_idx] : 1'b0;

		if (cmd.em_start) word_q <= '0;
		else if (cmd.word_cap && reg_in_range) word_q <= reg_vld_s1 ? reg_rdata : '0;
	end

	// Response bytes
	always_comb begin
		case (head_k_q)
			3'd0: head_byte = slave_addr_q;
			3'd1: head_byte = hdr_q[1];
			3'd2: head_byte = (kind == K_READ) ? {hdr_q[5][6:0], 1'b0} : hdr_q[2];
			3'd3: head_byte = hdr_q[3];
			3'd4: head_byte = hdr_q[4];
			3'd5: head_byte = hdr_q[5];
			default: head_byte = hdr_q[5];
		endcase
	end

	always_comb begin
		case (cmd.tx_sel)
			SEL_WHI:   tx_next = word_q[15:8];
			SEL_WLO:   tx_next = word_q[7:0];
			SEL_CRCLO: tx_next = tx_crc_q[7:0];
			SEL_CRCHI: tx_next = tx_crc_q[15:8];
			default:   tx_next = head_byte;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.em_start) begin
			head_k_q <= '0;
			tx_crc_q <= CRC_INIT;
		end else begin
			if (cmd.head_adv) head_k_q <= head_k_q + 1'b1;
			if (cmd.emit && (cmd.tx_sel == SEL_HEAD || cmd.tx_sel == SEL_WHI
					|| cmd.tx_sel == SEL_WLO)) begin
				tx_crc_q <= crc_byte(tx_crc_q, tx_next);
			end
		end
	end

	// Output register
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			tx_byte_q  <= tx_next;
			last_q     <= (cmd.tx_sel == SEL_CRCHI);
			save_out_q <= save_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign tx_byte      = tx_byte_q;
	assign last_byte    = last_q;
	assign save_request = save_out_q;

	// Status to the controller
	always_comb begin
		st.count_gt4     = count_q > CNT_W'(MIN_CHECK_CNT);
		st.kind          = kind;
		case (kind)
			K_WCOILS: st.frame_ready = {1'b0, count_q} >= len15;
			K_WMULTI: st.frame_ready = 18'(count_q) >= len16;
			default:  st.frame_ready = count_q >= CNT_W'(BASIC_LEN);
		endcase
		st.accept        = (hdr_q[0] == slave_addr_q) && !err_q;
		st.hdr_last      = rd_idx_q == CNT_W'(HDR_LEN - 1);
		st.ck_last       = rd_idx_q == ck_len - 8'd1;
		st.crc_ok        = lo_ok_q && hi_ok_q;
		st.read_too_long = hdr_cnt > 16'(MAX_READ);
		st.read_empty    = hdr_cnt == '0;
		st.wm_done       = 16'(widx_q) == hdr_cnt;
		st.head_last     = head_k_q == ((kind == K_READ) ? 3'(HEAD_LEN_READ - 1)
			: 3'(HEAD_LEN_WRITE - 1));
		st.words_last    = (16'(widx_q) + 16'd1) == hdr_cnt;
		st.out_free      = out_free;
	end

endmodule

FILE: sv/modbus_rtu_slave_register_server_unit.sv
// ----------------------------------------------------------------------------
// modbus_rtu_slave_register_server_unit
// Modbus RTU slave: buffers request bytes, checks address, parity and CRC,
// serves read/write holding register requests and emits the response.
// ----------------------------------------------------------------------------
// Channel  | Signals                                        | Direction
// rx       | in_valid, in_stall, rx_byte, frame_start,      | in
//          | parity_error                                   |
// tx       | out_valid, out_stall, tx_byte, last_byte,      | out
//          | save_request                                   |
// cfg      | cfg_wr_en, cfg_wr_data (slave address)         | in
//
// One byte at a time: with fewer than five bytes buffered the byte is only
// stored; otherwise the header is fetched and decoded, the CRC is checked
// through the single buffer read port, a multi-write stores its registers
// in turn, a read response fetches each word, and the frame is consumed;
// header and CRC bytes go out one per cycle when out_stall is low. Reset
// clears the count, error flag and register valid bits at once (no clearing
// pass). in_stall is high while a byte is being processed; a stalled
// response byte holds in the output register.
// ----------------------------------------------------------------------------
module modbus_rtu_slave_register_server_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [7:0] cfg_wr_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	input  logic       frame_start,
	input  logic       parity_error,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] tx_byte,
	output logic       last_byte,
	output logic       save_request
);

	import mbrtu_pkg::*;

	cmd_t    cmd;
	status_t st;

	mbrtu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.st       (st),
		.cmd      (cmd)
	);

	mbrtu_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.rx_byte      (rx_byte),
		.frame_start  (frame_start),
		.parity_error (parity_error),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.tx_byte      (tx_byte),
		.last_byte    (last_byte),
		.save_request (save_request),
		.cmd          (cmd),
		.st           (st)
	);

`ifndef ASSERT_OFF
	// Busy right after taking a byte
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input not stalled after transaction");

	// Responses are only produced while a byte is being processed
	a_emit_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("response byte produced while idle");
`endif

endmodule
